### src/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types and constants of the multichannel PID block
// Field widths, register indexes, command codes and the state entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

  localparam int unsigned CH_W         = 8;
  localparam int unsigned CH_SPACE     = 2 ** CH_W;
  localparam int unsigned CHANNELS_DEF = 256;
  localparam int unsigned SMP_W        = 16;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned LIM_W        = 23;
  localparam int unsigned ERR_W        = SMP_W + 1;
  localparam int unsigned INTEG_W      = LIM_W + 1;
  localparam int unsigned DERIV_W      = ERR_W + 1;
  localparam int unsigned DRIVE_W      = 32;
  localparam int unsigned FRAC_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = LIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 2'd0,
    CFG_INTEG_GAIN  = 2'd1,
    CFG_DERIV_GAIN  = 2'd2,
    CFG_INTEG_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_COMPUTE = 1'b0,
    CMD_CLEAR   = 1'b1
  } cmd_e;

  // one channel's stored state
  typedef struct packed {
    logic signed [INTEG_W-1:0] integ;
    logic signed [ERR_W-1:0]   prev_err;
  } entry_t;

endpackage

`default_nettype wire

### src/pidaw_if.sv
// ----------------------------------------------------------------------------
// pidaw_if: request channels of the multichannel PID block
// Input request channel and drive result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pidaw_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [pidaw_pkg::CH_W-1:0]          channel;
  logic signed [pidaw_pkg::SMP_W-1:0]  target;
  logic signed [pidaw_pkg::SMP_W-1:0]  sample;
  logic                                last_in;

  modport source (output valid, command, channel, target, sample, last_in, input ready);
  modport sink   (input valid, command, channel, target, sample, last_in, output ready);
endinterface

interface pidaw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [pidaw_pkg::CH_W-1:0]           out_channel;
  logic signed [pidaw_pkg::DRIVE_W-1:0] drive;
  logic                                 clipped;
  logic                                 last_out;

  modport source (output valid, out_channel, drive, clipped, last_out, input ready);
  modport sink   (input valid, out_channel, drive, clipped, last_out, output ready);
endinterface

`default_nettype wire

### src/pidaw_ram.sv
// ----------------------------------------------------------------------------
// pidaw_ram: channel state memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_ram #(
  parameter  int unsigned Depth = 256,
  parameter  int unsigned Width = 41,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/pid_antiwindup_multichannel_top.sv
// ----------------------------------------------------------------------------
// pid_antiwindup_multichannel_top: multichannel PID with integral clamp
// Per-channel PID drive computation with anti-windup and state in memory.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless a stalled output backs up the
// pipeline, and returns one drive result per compute request through stage
// 1, stage 2, stage 3 and the output register; a clear takes one slot and
// returns nothing. The rate is set by the single state memory: each compute
// reads its channel's entry on acceptance and writes the updated entry back
// as it leaves stage 1, and a request for the channel just written picks the
// fresh values off a forwarding register. Per-entry valid bits in flip-flops
// make reset and clear immediate, so there is no clearing pass. Indexes at or
// above CHANNELS compute with zero state and store nothing. Stages drain
// independently: requests are taken while a result waits if a stage is free.
`default_nettype none

module pid_antiwindup_multichannel_top #(
  parameter int unsigned CHANNELS = pidaw_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  pidaw_in_if.sink                               in_i,
  pidaw_out_if.source                            out_o
);

  import pidaw_pkg::*;

  // only channel codes below both CHANNELS and the index range need storage
  localparam int unsigned MemDepth = (CHANNELS < CH_SPACE) ? CHANNELS : CH_SPACE;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned PropW    = GAIN_W + ERR_W;
  localparam int unsigned IntW     = GAIN_W + INTEG_W;
  localparam int unsigned DerW     = GAIN_W + DERIV_W;
  localparam int unsigned SumW     = IntW + 2;
  localparam int unsigned DrvFullW = SumW - FRAC_W;

  // configuration
  logic signed [GAIN_W-1:0] kp_q, ki_q, kd_q;
  logic        [LIM_W-1:0]  lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      lim_q <= LIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PROP_GAIN:   kp_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN:  ki_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_DERIV_GAIN:  kd_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_LIMIT: lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage enables: each stage moves when it is empty or the next one moves
  logic en_out, en3, en2, en1;
  logic out_v_q, s3_v_q, s2_v_q, s1_v_q;

  assign en_out = !out_v_q || out_o.ready;
  assign en3    = !s3_v_q || en_out;
  assign en2    = !s2_v_q || en3;
  assign en1    = !s1_v_q || en2;

  assign in_i.ready = en1;

  logic in_acc, in_range;
  assign in_acc   = in_i.valid && en1;
  assign in_range = (32'(in_i.channel) < CHANNELS);

  // ---- stage 1: entry read in flight, error precomputed -------------------
  logic                    s1_cmd_q, s1_last_q, s1_rng_q;
  logic [CH_W-1:0]         s1_ch_q;
  logic signed [ERR_W-1:0] s1_err_q;

  logic [AddrW-1:0] raddr, s1_addr;
  assign raddr   = AddrW'(in_i.channel);
  assign s1_addr = AddrW'(s1_ch_q);

  // ---- state memory and valid bits ---------------------------------------
  entry_t ram_rdata, wr_entry;
  logic   ram_we;

  pidaw_ram #(
    .Depth (MemDepth),
    .Width ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr),
    .wdata_i (wr_entry),
    .re_i    (in_acc && in_range),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  logic [MemDepth-1:0] vld_q;
  logic                fwd_v_q;
  logic [AddrW-1:0]    fwd_addr_q;
  entry_t              fwd_q;

  logic s1_go, s1_clear, s1_compute;
  assign s1_go      = s1_v_q && en2;
  assign s1_clear   = s1_go && (s1_cmd_q == CMD_CLEAR);
  assign s1_compute = s1_go && (s1_cmd_q == CMD_COMPUTE);
  assign ram_we     = s1_compute && s1_rng_q;

  // current state: forwarded write, stored entry, or zero when invalid
  entry_t cur;
  always_comb begin
    cur = '0;
    if (s1_rng_q) begin
      if (fwd_v_q && (fwd_addr_q == s1_addr)) begin
        cur = fwd_q;
      end else if (vld_q[s1_addr]) begin
        cur = ram_rdata;
      end
    end
  end

  // integral update with clamp, derivative
  logic signed [INTEG_W:0]   acc, lim_pos, lim_neg;
  logic signed [INTEG_W-1:0] integ_new;
  logic signed [DERIV_W-1:0] deriv;

  always_comb begin
    acc     = (INTEG_W+1)'(cur.integ) + (INTEG_W+1)'(s1_err_q);
    lim_pos = $signed({2'b00, lim_q});
    lim_neg = -lim_pos;
    if (acc > lim_pos) begin
      integ_new = lim_pos[INTEG_W-1:0];
    end else if (acc < lim_neg) begin
      integ_new = lim_neg[INTEG_W-1:0];
    end else begin
      integ_new = acc[INTEG_W-1:0];
    end
    deriv = DERIV_W'(s1_err_q) - DERIV_W'(cur.prev_err);
  end

  assign wr_entry.integ    = integ_new;
  assign wr_entry.prev_err = s1_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      fwd_v_q <= 1'b0;
    end else if (s1_clear) begin
      vld_q   <= '0;
      fwd_v_q <= 1'b0;
    end else if (ram_we) begin
      vld_q[s1_addr] <= 1'b1;
      fwd_v_q        <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      fwd_addr_q <= s1_addr;
      fwd_q      <= wr_entry;
    end
  end

  // ---- stages 2 and 3: products, then sum and saturation -----------------
  logic [CH_W-1:0]           s2_ch_q, s3_ch_q;
  logic                      s2_last_q, s3_last_q;
  logic signed [ERR_W-1:0]   s2_err_q;
  logic signed [INTEG_W-1:0] s2_integ_q;
  logic signed [DERIV_W-1:0] s2_deriv_q;
  logic signed [PropW-1:0]   s3_pp_q;
  logic signed [IntW-1:0]    s3_pi_q;
  logic signed [DerW-1:0]    s3_pd_q;

  logic signed [SumW-1:0]     sum;
  logic signed [DrvFullW-1:0] drv_full;
  logic                       clip;
  logic signed [DRIVE_W-1:0]  drv_sat;

  always_comb begin
    sum      = SumW'(s3_pp_q) + SumW'(s3_pi_q) + SumW'(s3_pd_q);
    drv_full = DrvFullW'(sum >>> FRAC_W);
    // fits in DRIVE_W bits iff the top bits all match the sign
    clip     = (drv_full[DrvFullW-1:DRIVE_W-1] != {(DrvFullW-DRIVE_W+1){1'b0}}) &&
               (drv_full[DrvFullW-1:DRIVE_W-1] != {(DrvFullW-DRIVE_W+1){1'b1}});
    if (!clip) begin
      drv_sat = drv_full[DRIVE_W-1:0];
    end else if (drv_full[DrvFullW-1]) begin
      drv_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drv_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    s1_v_q  <= in_i.valid;
      if (en2)    s2_v_q  <= s1_v_q && (s1_cmd_q == CMD_COMPUTE);
      if (en3)    s3_v_q  <= s2_v_q;
      if (en_out) out_v_q <= s3_v_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= in_i.command;
      s1_ch_q   <= in_i.channel;
      s1_last_q <= in_i.last_in;
      s1_rng_q  <= in_range;
      s1_err_q  <= ERR_W'(in_i.target) - ERR_W'(in_i.sample);
    end
    if (en2) begin
      s2_ch_q    <= s1_ch_q;
      s2_last_q  <= s1_last_q;
      s2_err_q   <= s1_err_q;
      s2_integ_q <= integ_new;
      s2_deriv_q <= deriv;
    end
    if (en3) begin
      s3_ch_q   <= s2_ch_q;
      s3_last_q <= s2_last_q;
      s3_pp_q   <= kp_q * s2_err_q;
      s3_pi_q   <= ki_q * s2_integ_q;
      s3_pd_q   <= kd_q * s2_deriv_q;
    end
    if (en_out) begin
      out_o.out_channel <= s3_ch_q;
      out_o.last_out    <= s3_last_q;
      out_o.drive       <= drv_sat;
      out_o.clipped     <= clip;
    end
  end

  assign out_o.valid = out_v_q;

endmodule

`default_nettype wire

### src/pidaw_checker.sv
// ----------------------------------------------------------------------------
// pidaw_checker: port-level checks of the multichannel PID block
// Watches the top level's channels; attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_channel_i,
  input wire logic [31:0] drive_i,
  input wire logic        clipped_i,
  input wire logic        last_out_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(drive_i) &&
    $stable(clipped_i) && $stable(out_channel_i) && $stable(last_out_i))
    else $error("stalled result changed");

  // saturation only ever lands on the range limits
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clipped_i |-> (drive_i == 32'h7FFF_FFFF) || (drive_i == 32'h8000_0000))
    else $error("clipped drive not at a range limit");

  // with an empty output register the pipeline cannot be backed up
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output empty");

endmodule

bind pid_antiwindup_multichannel_top pidaw_checker u_pidaw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_channel_i (out_o.out_channel),
  .drive_i       (out_o.drive),
  .clipped_i     (out_o.clipped),
  .last_out_i    (out_o.last_out)
);

`default_nettype wire
